// ----- design/csvp_pkg.sv -----
`default_nettype none

package csvp_pkg;

   // widths fixed by the word format
   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned VALUE_W = 32;
   localparam int unsigned SLOT_W  = 5;
   localparam int unsigned COUNT_W = 6;
   localparam int unsigned POS_W   = 8;

   // limits and characters
   localparam logic [COUNT_W-1:0] SLOT_LIMIT    = 6'd32;
   localparam logic [COUNT_W-1:0] MAX_VALUES_RST = 6'd32;
   localparam logic [VALUE_W-1:0] MAG_CAP       = 32'h8000_0000;
   localparam logic [VALUE_W-1:0] POS_MAX       = 32'h7FFF_FFFF;
   localparam logic [BYTE_W-1:0]  CHAR_COMMA    = 8'h2C;
   localparam logic [BYTE_W-1:0]  CHAR_PLUS     = 8'h2B;
   localparam logic [BYTE_W-1:0]  CHAR_MINUS    = 8'h2D;
   localparam logic [BYTE_W-1:0]  CHAR_NUL      = 8'h00;
   localparam logic [BYTE_W-1:0]  CHAR_SPACE    = 8'h20;
   localparam logic [BYTE_W-1:0]  CHAR_TAB      = 8'h09;
   localparam logic [BYTE_W-1:0]  CHAR_CR       = 8'h0D;
   localparam logic [BYTE_W-1:0]  CHAR_ZERO     = 8'h30;
   localparam logic [BYTE_W-1:0]  CHAR_NINE     = 8'h39;

   // phase of the field being parsed
   typedef enum logic [1:0] {
      PHASE_SKIP   = 2'd0,
      PHASE_DIGITS = 2'd1,
      PHASE_DONE   = 2'd2
   } phase_type;

   // input word
   typedef struct packed {
      logic [BYTE_W-1:0] rx_byte;
      logic              frame_start;
   } req_type;

   // result word
   typedef struct packed {
      logic signed [VALUE_W-1:0] field_value;
      logic [SLOT_W-1:0]         field_slot;
   } rsp_type;

endpackage

`default_nettype wire

// ----- design/csvp_parse.sv -----
`default_nettype none

module csvp_parse #(
   parameter int unsigned WINDOW = 50
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          step,
   input  wire csvp_pkg::req_type             word,
   input  wire logic [csvp_pkg::COUNT_W-1:0]  max_values,
   output logic                               emit,
   output csvp_pkg::rsp_type                  result
);

   localparam logic [csvp_pkg::POS_W-1:0] WINDOW_POS = csvp_pkg::POS_W'(WINDOW);

   logic [csvp_pkg::POS_W-1:0]   pos_ff, pos_in;
   logic [csvp_pkg::COUNT_W-1:0] emitted_ff, emitted_in;
   logic [csvp_pkg::VALUE_W-1:0] acc_ff, acc_in;
   logic                         neg_ff, neg_in;
   csvp_pkg::phase_type          phase_ff, phase_in;
   logic                         nonempty_ff, nonempty_in;
   logic                         stopped_ff, stopped_in;

   // frame state as seen after an optional frame start
   logic [csvp_pkg::POS_W-1:0]   pos_e;
   logic [csvp_pkg::COUNT_W-1:0] emitted_e;
   logic [csvp_pkg::VALUE_W-1:0] acc_e;
   logic                         neg_e;
   csvp_pkg::phase_type          phase_e;
   logic                         nonempty_e;
   logic                         stopped_e;

   logic [csvp_pkg::COUNT_W-1:0] limit;
   logic [csvp_pkg::COUNT_W-1:0] emitted_inc;
   logic [csvp_pkg::BYTE_W-1:0]  c;
   logic                         is_space;
   logic                         is_digit;
   logic [35:0]                  mul10;
   logic [csvp_pkg::VALUE_W-1:0] acc_digit;
   logic [csvp_pkg::VALUE_W-1:0] value;
   logic                         digit_path;

   // character classes
   assign c        = word.rx_byte;
   assign is_space = (c == csvp_pkg::CHAR_SPACE) ||
                     (c inside {[csvp_pkg::CHAR_TAB:csvp_pkg::CHAR_CR]});
   assign is_digit = c inside {[csvp_pkg::CHAR_ZERO:csvp_pkg::CHAR_NINE]};

   // state after frame start clear
   always_comb begin
      if (word.frame_start) begin
         pos_e      = '0;
         emitted_e  = '0;
         stopped_e  = 1'b0;
         acc_e      = '0;
         neg_e      = 1'b0;
         phase_e    = csvp_pkg::PHASE_SKIP;
         nonempty_e = 1'b0;
      end else begin
         pos_e      = pos_ff;
         emitted_e  = emitted_ff;
         stopped_e  = stopped_ff;
         acc_e      = acc_ff;
         neg_e      = neg_ff;
         phase_e    = phase_ff;
         nonempty_e = nonempty_ff;
      end
   end

   assign limit       = (max_values > csvp_pkg::SLOT_LIMIT) ? csvp_pkg::SLOT_LIMIT : max_values;
   assign emitted_inc = emitted_e + 1'b1;

   // multiply by ten and add the digit, saturated at 2^31
   assign mul10 = {1'b0, acc_e, 3'b000} + {3'b000, acc_e, 1'b0}
                + {28'd0, c - csvp_pkg::CHAR_ZERO};
   assign acc_digit = (mul10 > {4'd0, csvp_pkg::MAG_CAP}) ? csvp_pkg::MAG_CAP
                                                         : mul10[csvp_pkg::VALUE_W-1:0];

   // signed field value
   always_comb begin
      if (neg_e) begin
         value = '0 - acc_e;
      end else if (acc_e > csvp_pkg::POS_MAX) begin
         value = csvp_pkg::POS_MAX;
      end else begin
         value = acc_e;
      end
   end

   assign result.field_value = $signed(value);
   assign result.field_slot  = emitted_e[csvp_pkg::SLOT_W-1:0];

   // next state and emit
   always_comb begin
      pos_in      = pos_e;
      emitted_in  = emitted_e;
      stopped_in  = stopped_e;
      acc_in      = acc_e;
      neg_in      = neg_e;
      phase_in    = phase_e;
      nonempty_in = nonempty_e;
      emit        = 1'b0;
      digit_path  = 1'b0;
      if (stopped_e || (emitted_e >= limit)) begin
         stopped_in = 1'b1;
      end else if (pos_e >= WINDOW_POS) begin
         // outside the window: nothing changes
      end else begin
         pos_in = pos_e + 1'b1;
         if (c == csvp_pkg::CHAR_COMMA) begin
            if (nonempty_e) begin
               emit       = 1'b1;
               emitted_in = emitted_inc;
               if (emitted_inc >= limit) begin
                  stopped_in = 1'b1;
               end
            end
            acc_in      = '0;
            neg_in      = 1'b0;
            phase_in    = csvp_pkg::PHASE_SKIP;
            nonempty_in = 1'b0;
         end else begin
            nonempty_in = 1'b1;
            if (c == csvp_pkg::CHAR_NUL) begin
               phase_in = csvp_pkg::PHASE_DONE;
            end else begin
               case (phase_e)
                  csvp_pkg::PHASE_SKIP: begin
                     if (is_space) begin
                        // leading whitespace
                     end else if ((c == csvp_pkg::CHAR_PLUS) || (c == csvp_pkg::CHAR_MINUS)) begin
                        neg_in   = (c == csvp_pkg::CHAR_MINUS);
                        phase_in = csvp_pkg::PHASE_DIGITS;
                     end else begin
                        digit_path = 1'b1;
                     end
                  end
                  csvp_pkg::PHASE_DIGITS: begin
                     digit_path = 1'b1;
                  end
                  default: begin
                     // done: ignore until the comma
                  end
               endcase
               if (digit_path) begin
                  if (is_digit) begin
                     acc_in   = acc_digit;
                     phase_in = csvp_pkg::PHASE_DIGITS;
                  end else begin
                     phase_in = csvp_pkg::PHASE_DONE;
                  end
               end
            end
         end
      end
   end

   // parser state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         emitted_ff  <= '0;
         acc_ff      <= '0;
         neg_ff      <= 1'b0;
         phase_ff    <= csvp_pkg::PHASE_SKIP;
         nonempty_ff <= 1'b0;
         stopped_ff  <= 1'b0;
      end else if (step) begin
         pos_ff      <= pos_in;
         emitted_ff  <= emitted_in;
         acc_ff      <= acc_in;
         neg_ff      <= neg_in;
         phase_ff    <= phase_in;
         nonempty_ff <= nonempty_in;
         stopped_ff  <= stopped_in;
      end
   end

endmodule

`default_nettype wire

// ----- design/csv_decimal_field_parser.sv -----
`default_nettype none

// path: a word accepted into the input register is parsed combinationally, and its
// result is captured in the output register once the output is free
// throughput: one byte per cycle while the output is not stalled; the parser state
// (accumulate by ten and the field phase) is updated between the two registers
// reset: synchronous, clears the parser to a fresh frame and sets max_values to 32

module csv_decimal_field_parser #(
   parameter int unsigned WINDOW = 50
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire csvp_pkg::req_type             req_data,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output csvp_pkg::rsp_type                  rsp_data,
   input  wire logic                          csr_wr_en,
   input  wire logic [csvp_pkg::COUNT_W-1:0]  csr_wr_data
);

   logic                         in_valid_ff, in_valid_in;
   csvp_pkg::req_type            in_data_ff;
   logic                         out_valid_ff, out_valid_in;
   csvp_pkg::rsp_type            out_data_ff;
   logic [csvp_pkg::COUNT_W-1:0] max_values_ff;
   logic                         advance;
   logic                         emit;
   csvp_pkg::rsp_type            result;

   // word moves from input to output register when the output is free
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (!req_stall) begin
         in_valid_in = req_valid;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = emit;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         max_values_ff <= csvp_pkg::MAX_VALUES_RST;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_wr_en) begin
            max_values_ff <= csr_wr_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= result;
      end
   end

   // parser
   csvp_parse #(
      .WINDOW(WINDOW)
   ) u_parse (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .word       (in_data_ff),
      .max_values (max_values_ff),
      .emit       (emit),
      .result     (result)
   );

endmodule

`default_nettype wire
